// File: design/rc_channel_conditioner_top_defines.svh
// assertion macros for the rc channel conditioner
`ifndef RC_CHANNEL_CONDITIONER_TOP_DEFINES_SVH
`define RC_CHANNEL_CONDITIONER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define RCC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcc assertion failed");

`define RCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcc assertion failed");

`else

`define RCC_ASSERT_IMPL(lbl, clk, rst, ante, cons)

`define RCC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: design/rcc_pkg.sv
// types and constants shared by the rc channel conditioner
package rcc_pkg;

   localparam int RAW_BITS       = 11;
   localparam int FRAC_BITS      = 15;
   localparam int SCALE_BITS     = 16;
   localparam int DB_BITS        = 15;
   localparam int ALPHA_BITS     = 16;
   localparam int AGE_BITS       = 16;
   localparam int ELAPSED_BITS   = 8;
   localparam int NORM_SHIFT     = 25 - FRAC_BITS;
   localparam int AXIS_BITS      = FRAC_BITS + 1;
   localparam int NUM_CH         = 5;
   localparam int NUM_AXES       = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam int IDX_ROLL     = 0;
   localparam int IDX_PITCH    = 1;
   localparam int IDX_YAW      = 2;
   localparam int IDX_THROTTLE = 3;
   localparam int IDX_ARM      = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_INPUT_MIN     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NORM_SCALE    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEADBAND      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SMOOTH_ALPHA  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT_MS    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ARM_THRESHOLD = 3'd5;

   localparam logic [RAW_BITS-1:0]   RST_INPUT_MIN     = 11'd172;
   localparam logic [SCALE_BITS-1:0] RST_NORM_SCALE    = 16'd20472;
   localparam logic [DB_BITS-1:0]    RST_DEADBAND      = 15'd1638;
   localparam logic [ALPHA_BITS-1:0] RST_SMOOTH_ALPHA  = 16'd9830;
   localparam logic [AGE_BITS-1:0]   RST_TIMEOUT_MS    = 16'd100;
   localparam logic [RAW_BITS-1:0]   RST_ARM_THRESHOLD = 11'd1000;

   localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = ALPHA_BITS'(2 ** FRAC_BITS);
   localparam logic [AGE_BITS-1:0]   AGE_MAX   = '1;

   typedef struct packed {
      logic                    frame_valid;
      logic [RAW_BITS-1:0]     roll_raw;
      logic [RAW_BITS-1:0]     pitch_raw;
      logic [RAW_BITS-1:0]     yaw_raw;
      logic [RAW_BITS-1:0]     throttle_raw;
      logic [RAW_BITS-1:0]     arm_raw;
      logic                    failsafe;
      logic [ELAPSED_BITS-1:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic signed [AXIS_BITS-1:0] roll_out;
      logic signed [AXIS_BITS-1:0] pitch_out;
      logic signed [AXIS_BITS-1:0] yaw_out;
      logic [FRAC_BITS-1:0]        throttle_out;
      logic                        is_armed;
      logic                        signal_lost;
   } rsp_type;

   typedef struct packed {
      logic mul_en;
      logic map_en;
      logic smo_en;
      logic upd_en;
   } lane_ctrl_type;

   typedef struct packed {
      logic [RAW_BITS-1:0]   input_min;
      logic [SCALE_BITS-1:0] norm_scale;
      logic [DB_BITS-1:0]    deadband;
      logic [ALPHA_BITS-1:0] alpha;
   } lane_cfg_type;

endpackage

// File: design/rcc_lane.sv
// one axis lane: normalize, clamp, deadband (symmetric axes only) and smoothing filter
module rcc_lane (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   sym_mode,
   input  logic [rcc_pkg::RAW_BITS-1:0]           raw,
   input  rcc_pkg::lane_cfg_type                  cfg,
   input  rcc_pkg::lane_ctrl_type                 ctrl,
   output logic signed [rcc_pkg::AXIS_BITS-1:0]   r_next
);

   localparam int PROD_BITS = rcc_pkg::RAW_BITS + 1 + rcc_pkg::SCALE_BITS + 1;
   localparam int NORM_BITS = PROD_BITS - rcc_pkg::NORM_SHIFT;
   localparam int SYM_BITS  = NORM_BITS + 2;
   localparam int DX_BITS   = rcc_pkg::AXIS_BITS + 1;
   localparam int D_BITS    = DX_BITS + rcc_pkg::ALPHA_BITS + 1;
   localparam int Q_ONE     = 2 ** rcc_pkg::FRAC_BITS;

   logic signed [rcc_pkg::RAW_BITS:0]        diff;
   logic signed [PROD_BITS-1:0]              prod_ff, prod_in;
   logic signed [PROD_BITS-1:0]              prod_sh;
   logic signed [NORM_BITS-1:0]              norm;
   logic signed [SYM_BITS-1:0]               sym;
   logic signed [SYM_BITS-1:0]               sym_clamped;
   logic signed [SYM_BITS-1:0]               sym_mag;
   logic signed [NORM_BITS-1:0]              thr_clamped;
   logic signed [rcc_pkg::AXIS_BITS-1:0]     x_ff, x_in;
   logic signed [DX_BITS-1:0]                dx;
   logic signed [D_BITS-1:0]                 d_ff, d_in;
   logic signed [D_BITS-1:0]                 r_wide;
   logic signed [rcc_pkg::AXIS_BITS-1:0]     r_ff;

   assign diff    = $signed({1'b0, raw}) - $signed({1'b0, cfg.input_min});
   assign prod_in = diff * $signed({1'b0, cfg.norm_scale});

   assign prod_sh = prod_ff >>> rcc_pkg::NORM_SHIFT;
   assign norm    = prod_sh[NORM_BITS-1:0];

   assign sym = (SYM_BITS'(norm) <<< 1) - SYM_BITS'(Q_ONE);

   always_comb begin
      if (sym < -SYM_BITS'(Q_ONE)) begin
         sym_clamped = -SYM_BITS'(Q_ONE);
      end else if (sym > SYM_BITS'(Q_ONE - 1)) begin
         sym_clamped = SYM_BITS'(Q_ONE - 1);
      end else begin
         sym_clamped = sym;
      end
      sym_mag = sym_clamped[SYM_BITS-1] ? -sym_clamped : sym_clamped;

      if (norm < 0) begin
         thr_clamped = '0;
      end else if (norm > NORM_BITS'(Q_ONE - 1)) begin
         thr_clamped = NORM_BITS'(Q_ONE - 1);
      end else begin
         thr_clamped = norm;
      end

      if (sym_mode) begin
         if (sym_mag < $signed(SYM_BITS'(cfg.deadband))) begin
            x_in = '0;
         end else begin
            x_in = sym_clamped[rcc_pkg::AXIS_BITS-1:0];
         end
      end else begin
         x_in = thr_clamped[rcc_pkg::AXIS_BITS-1:0];
      end
   end

   assign dx     = DX_BITS'(x_ff) - DX_BITS'(r_ff);
   assign d_in   = $signed({1'b0, cfg.alpha}) * dx;
   assign r_wide = (d_ff >>> rcc_pkg::FRAC_BITS) + D_BITS'(r_ff);
   assign r_next = r_wide[rcc_pkg::AXIS_BITS-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.map_en) begin
         x_ff <= x_in;
      end
      if (ctrl.smo_en) begin
         d_ff <= d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff <= '0;
      end else if (ctrl.upd_en) begin
         r_ff <= r_next;
      end
   end

endmodule

// File: design/rcc_merge.sv
// merges lane results and status flags into the output register
module rcc_merge (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  logic                                                    load,
   input  logic [rcc_pkg::NUM_AXES-1:0][rcc_pkg::AXIS_BITS-1:0]    lane_val,
   input  logic                                                    armed,
   input  logic                                                    lost,
   output logic                                                    out_free,
   output logic                                                    rsp_valid,
   input  logic                                                    rsp_ready,
   output rcc_pkg::rsp_type                                        rsp_data
);

   logic             rsp_valid_ff;
   rcc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_data_in.roll_out     = $signed(lane_val[rcc_pkg::IDX_ROLL]);
      rsp_data_in.pitch_out    = $signed(lane_val[rcc_pkg::IDX_PITCH]);
      rsp_data_in.yaw_out      = $signed(lane_val[rcc_pkg::IDX_YAW]);
      rsp_data_in.throttle_out = lane_val[rcc_pkg::IDX_THROTTLE][rcc_pkg::FRAC_BITS-1:0];
      rsp_data_in.is_armed     = armed;
      rsp_data_in.signal_lost  = lost;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: design/rc_channel_conditioner_top.sv
// top level of the rc channel conditioner
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    rcc_pkg::req_type
//   rsp      out        rsp_valid/rsp_ready    rcc_pkg::rsp_type
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// each item passes latch, multiply, map, smoothing multiply and update
// the four axis lanes run side by side through the same four-step sequence
// the final step waits while the output register holds an untaken result
// synchronous reset clears latched channels, age, filters and rsp_valid
// and loads the csr defaults; csr writes are always taken
`include "rc_channel_conditioner_top_defines.svh"

module rc_channel_conditioner_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  rcc_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output rcc_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rcc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [rcc_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_MAP,
      S_SMOOTH,
      S_UPDATE
   } state_type;

   state_type                                               state_ff, state_in;
   logic [rcc_pkg::RAW_BITS-1:0]                            store_ff [rcc_pkg::NUM_CH];
   logic                                                    failsafe_ff;
   logic [rcc_pkg::AGE_BITS-1:0]                            frame_age_ff, frame_age_in;
   logic [rcc_pkg::AGE_BITS:0]                              age_sum;

   logic [rcc_pkg::RAW_BITS-1:0]                            input_min_ff;
   logic [rcc_pkg::SCALE_BITS-1:0]                          norm_scale_ff;
   logic [rcc_pkg::DB_BITS-1:0]                             deadband_ff;
   logic [rcc_pkg::ALPHA_BITS-1:0]                          alpha_ff;
   logic [rcc_pkg::AGE_BITS-1:0]                            timeout_ff;
   logic [rcc_pkg::RAW_BITS-1:0]                            arm_thr_ff;

   logic                                                    req_accept;
   logic                                                    good_frame;
   logic                                                    out_free;
   logic                                                    armed;
   logic                                                    lost;
   rcc_pkg::lane_ctrl_type                                  lane_ctrl;
   rcc_pkg::lane_cfg_type                                   lane_cfg;
   logic [rcc_pkg::NUM_AXES-1:0][rcc_pkg::AXIS_BITS-1:0]    lane_val;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign good_frame = req_accept && req_data.frame_valid && !req_data.failsafe;
   assign csr_ready  = 1'b1;

   // saturating age, cleared by a good frame
   always_comb begin
      age_sum = {1'b0, frame_age_ff} + (rcc_pkg::AGE_BITS + 1)'(req_data.elapsed_ms);
      if (age_sum[rcc_pkg::AGE_BITS]) begin
         frame_age_in = rcc_pkg::AGE_MAX;
      end else begin
         frame_age_in = age_sum[rcc_pkg::AGE_BITS-1:0];
      end
      if (req_data.frame_valid && !req_data.failsafe) begin
         frame_age_in = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_MUL;
            end
         end
         S_MUL:    state_in = S_MAP;
         S_MAP:    state_in = S_SMOOTH;
         S_SMOOTH: state_in = S_UPDATE;
         S_UPDATE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         failsafe_ff  <= 1'b0;
         frame_age_ff <= '0;
         for (int i = 0; i < rcc_pkg::NUM_CH; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (req_accept) begin
            frame_age_ff <= frame_age_in;
            if (req_data.frame_valid) begin
               store_ff[rcc_pkg::IDX_ROLL]     <= req_data.roll_raw;
               store_ff[rcc_pkg::IDX_PITCH]    <= req_data.pitch_raw;
               store_ff[rcc_pkg::IDX_YAW]      <= req_data.yaw_raw;
               store_ff[rcc_pkg::IDX_THROTTLE] <= req_data.throttle_raw;
               store_ff[rcc_pkg::IDX_ARM]      <= req_data.arm_raw;
               failsafe_ff                     <= req_data.failsafe;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         input_min_ff  <= rcc_pkg::RST_INPUT_MIN;
         norm_scale_ff <= rcc_pkg::RST_NORM_SCALE;
         deadband_ff   <= rcc_pkg::RST_DEADBAND;
         alpha_ff      <= rcc_pkg::RST_SMOOTH_ALPHA;
         timeout_ff    <= rcc_pkg::RST_TIMEOUT_MS;
         arm_thr_ff    <= rcc_pkg::RST_ARM_THRESHOLD;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rcc_pkg::CSR_INPUT_MIN:     input_min_ff  <= csr_data[rcc_pkg::RAW_BITS-1:0];
            rcc_pkg::CSR_NORM_SCALE:    norm_scale_ff <= csr_data;
            rcc_pkg::CSR_DEADBAND:      deadband_ff   <= csr_data[rcc_pkg::DB_BITS-1:0];
            rcc_pkg::CSR_SMOOTH_ALPHA:  alpha_ff      <= csr_data;
            rcc_pkg::CSR_TIMEOUT_MS:    timeout_ff    <= csr_data;
            rcc_pkg::CSR_ARM_THRESHOLD: arm_thr_ff    <= csr_data[rcc_pkg::RAW_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      lane_ctrl.mul_en = (state_ff == S_MUL);
      lane_ctrl.map_en = (state_ff == S_MAP);
      lane_ctrl.smo_en = (state_ff == S_SMOOTH);
      lane_ctrl.upd_en = (state_ff == S_UPDATE) && out_free;

      lane_cfg.input_min  = input_min_ff;
      lane_cfg.norm_scale = norm_scale_ff;
      lane_cfg.deadband   = deadband_ff;
      lane_cfg.alpha      = (alpha_ff > rcc_pkg::ALPHA_ONE) ? rcc_pkg::ALPHA_ONE : alpha_ff;
   end

   assign armed = store_ff[rcc_pkg::IDX_ARM] > arm_thr_ff;
   assign lost  = failsafe_ff || (frame_age_ff > timeout_ff);

   for (genvar g = 0; g < rcc_pkg::NUM_AXES; g++) begin : g_lane
      rcc_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .sym_mode (g != rcc_pkg::IDX_THROTTLE),
         .raw      (store_ff[g]),
         .cfg      (lane_cfg),
         .ctrl     (lane_ctrl),
         .r_next   (lane_val[g])
      );
   end

   rcc_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (lane_ctrl.upd_en),
      .lane_val  (lane_val),
      .armed     (armed),
      .lost      (lost),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `RCC_ASSERT_NEXT(a_accept_starts, clock, reset, req_accept, state_ff == S_MUL)
   `RCC_ASSERT_IMPL(a_no_overwrite, clock, reset, lane_ctrl.upd_en, !rsp_valid || rsp_ready)
   `RCC_ASSERT_NEXT(a_age_holds, clock, reset, !req_accept, frame_age_ff == $past(frame_age_ff))
   `RCC_ASSERT_NEXT(a_age_clears, clock, reset, good_frame, frame_age_ff == '0)

endmodule

// File: tb/tb.sv
// testbench for rc_channel_conditioner_top: directed and random steps against a model
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [rcc_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [rcc_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 3'd7;
   localparam int     STALL_LIMIT  = 2000;
   localparam int     DRAIN_CYCLES = 8;
   localparam int     REPORT_LIMIT = 10;
   localparam longint Q_ONE        = longint'(1) << rcc_pkg::FRAC_BITS;

   logic                               clock     = 1'b0;
   logic                               reset     = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   rcc_pkg::req_type                   req_data  = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   rcc_pkg::rsp_type                   rsp_data;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [rcc_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [rcc_pkg::CSR_DATA_BITS-1:0]  csr_data  = '0;

   int               idle_odds      = 0;
   int               mismatch_count = 0;
   rcc_pkg::rsp_type axis_results_q[$];

   // mirrored registers and conditioner state
   logic [rcc_pkg::RAW_BITS-1:0]   cfg_input_min;
   logic [rcc_pkg::SCALE_BITS-1:0] cfg_norm_scale;
   logic [rcc_pkg::DB_BITS-1:0]    cfg_deadband;
   logic [rcc_pkg::ALPHA_BITS-1:0] cfg_alpha;
   logic [rcc_pkg::AGE_BITS-1:0]   cfg_timeout;
   logic [rcc_pkg::RAW_BITS-1:0]   cfg_arm_threshold;
   logic [rcc_pkg::RAW_BITS-1:0]   latched_raw [rcc_pkg::NUM_CH];
   logic                           latched_failsafe;
   logic [rcc_pkg::AGE_BITS-1:0]   age_ms;
   longint                         filter_axis [rcc_pkg::NUM_AXES];

   rc_channel_conditioner_top DUT (.*);

   always #1 clock = ~clock;

   function automatic void reset_model();
      cfg_input_min     = rcc_pkg::RST_INPUT_MIN;
      cfg_norm_scale    = rcc_pkg::RST_NORM_SCALE;
      cfg_deadband      = rcc_pkg::RST_DEADBAND;
      cfg_alpha         = rcc_pkg::RST_SMOOTH_ALPHA;
      cfg_timeout       = rcc_pkg::RST_TIMEOUT_MS;
      cfg_arm_threshold = rcc_pkg::RST_ARM_THRESHOLD;
      latched_failsafe  = 1'b0;
      age_ms            = '0;
      for (int i = 0; i < rcc_pkg::NUM_CH; i++) latched_raw[i] = '0;
      for (int i = 0; i < rcc_pkg::NUM_AXES; i++) filter_axis[i] = 0;
   endfunction

   // arithmetic shifts of signed values round toward minus infinity
   function automatic longint scale_raw(logic [rcc_pkg::RAW_BITS-1:0] raw);
      longint diff;
      diff = longint'(raw) - longint'(cfg_input_min);
      return (diff * longint'(cfg_norm_scale)) >>> rcc_pkg::NORM_SHIFT;
   endfunction

   function automatic longint sym_axis(logic [rcc_pkg::RAW_BITS-1:0] raw);
      longint v;
      longint mag;
      v = scale_raw(raw) * 2 - Q_ONE;
      if (v < -Q_ONE) v = -Q_ONE;
      else if (v > Q_ONE - 1) v = Q_ONE - 1;
      mag = (v < 0) ? -v : v;
      if (mag < longint'(cfg_deadband)) v = 0;
      return v;
   endfunction

   function automatic longint throttle_axis(logic [rcc_pkg::RAW_BITS-1:0] raw);
      longint v;
      v = scale_raw(raw);
      if (v < 0) v = 0;
      else if (v > Q_ONE - 1) v = Q_ONE - 1;
      return v;
   endfunction

   function automatic longint smooth_toward(longint r, longint x);
      longint a;
      a = (cfg_alpha > rcc_pkg::ALPHA_ONE) ? Q_ONE : longint'(cfg_alpha);
      return r + ((a * (x - r)) >>> rcc_pkg::FRAC_BITS);
   endfunction

   function automatic rcc_pkg::rsp_type condition_step(rcc_pkg::req_type it);
      longint           age_sum;
      longint           target [rcc_pkg::NUM_AXES];
      rcc_pkg::rsp_type r;
      age_sum = longint'(age_ms) + longint'(it.elapsed_ms);
      age_ms  = (age_sum > longint'(rcc_pkg::AGE_MAX)) ? rcc_pkg::AGE_MAX
                                                       : rcc_pkg::AGE_BITS'(age_sum);
      if (it.frame_valid) begin
         latched_raw[rcc_pkg::IDX_ROLL]     = it.roll_raw;
         latched_raw[rcc_pkg::IDX_PITCH]    = it.pitch_raw;
         latched_raw[rcc_pkg::IDX_YAW]      = it.yaw_raw;
         latched_raw[rcc_pkg::IDX_THROTTLE] = it.throttle_raw;
         latched_raw[rcc_pkg::IDX_ARM]      = it.arm_raw;
         latched_failsafe                   = it.failsafe;
         if (!it.failsafe) age_ms = '0;
      end
      target[rcc_pkg::IDX_ROLL]     = sym_axis(latched_raw[rcc_pkg::IDX_ROLL]);
      target[rcc_pkg::IDX_PITCH]    = sym_axis(latched_raw[rcc_pkg::IDX_PITCH]);
      target[rcc_pkg::IDX_YAW]      = sym_axis(latched_raw[rcc_pkg::IDX_YAW]);
      target[rcc_pkg::IDX_THROTTLE] = throttle_axis(latched_raw[rcc_pkg::IDX_THROTTLE]);
      for (int i = 0; i < rcc_pkg::NUM_AXES; i++) begin
         filter_axis[i] = smooth_toward(filter_axis[i], target[i]);
      end
      r.roll_out     = rcc_pkg::AXIS_BITS'(filter_axis[rcc_pkg::IDX_ROLL]);
      r.pitch_out    = rcc_pkg::AXIS_BITS'(filter_axis[rcc_pkg::IDX_PITCH]);
      r.yaw_out      = rcc_pkg::AXIS_BITS'(filter_axis[rcc_pkg::IDX_YAW]);
      r.throttle_out = rcc_pkg::FRAC_BITS'(filter_axis[rcc_pkg::IDX_THROTTLE]);
      r.is_armed     = latched_raw[rcc_pkg::IDX_ARM] > cfg_arm_threshold;
      r.signal_lost  = latched_failsafe || (age_ms > cfg_timeout);
      return r;
   endfunction

   function automatic rcc_pkg::req_type make_frame(int roll, int pitch, int yaw, int thr,
                                                   int arm, bit fs, int el);
      rcc_pkg::req_type it;
      it.frame_valid  = 1'b1;
      it.roll_raw     = rcc_pkg::RAW_BITS'(roll);
      it.pitch_raw    = rcc_pkg::RAW_BITS'(pitch);
      it.yaw_raw      = rcc_pkg::RAW_BITS'(yaw);
      it.throttle_raw = rcc_pkg::RAW_BITS'(thr);
      it.arm_raw      = rcc_pkg::RAW_BITS'(arm);
      it.failsafe     = fs;
      it.elapsed_ms   = rcc_pkg::ELAPSED_BITS'(el);
      return it;
   endfunction

   function automatic logic [rcc_pkg::RAW_BITS-1:0] random_raw();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return rcc_pkg::RAW_BITS'($urandom_range(150, 1850));
      if (sel < 9) return rcc_pkg::RAW_BITS'($urandom_range(0, 2047));
      return $urandom_range(0, 1) ? {rcc_pkg::RAW_BITS{1'b1}} : {rcc_pkg::RAW_BITS{1'b0}};
   endfunction

   function automatic rcc_pkg::req_type random_step();
      rcc_pkg::req_type it;
      int               sel;
      it.frame_valid  = ($urandom_range(0, 4) != 0);
      it.roll_raw     = random_raw();
      it.pitch_raw    = random_raw();
      it.yaw_raw      = random_raw();
      it.throttle_raw = random_raw();
      if ($urandom_range(0, 4) == 0) begin
         it.arm_raw = cfg_arm_threshold + rcc_pkg::RAW_BITS'($urandom_range(0, 1));
      end else begin
         it.arm_raw = random_raw();
      end
      it.failsafe = ($urandom_range(0, 9) == 0);
      sel = $urandom_range(0, 9);
      if (sel < 7) it.elapsed_ms = rcc_pkg::ELAPSED_BITS'($urandom_range(0, 15));
      else if (sel < 9) it.elapsed_ms = rcc_pkg::ELAPSED_BITS'($urandom_range(0, 255));
      else it.elapsed_ms = rcc_pkg::ELAPSED_BITS'($urandom_range(100, 255));
      return it;
   endfunction

   // step without a new frame, the other fields carry noise
   function automatic rcc_pkg::req_type idle_step(int el);
      rcc_pkg::req_type it;
      it             = random_step();
      it.frame_valid = 1'b0;
      it.elapsed_ms  = rcc_pkg::ELAPSED_BITS'(el);
      return it;
   endfunction

   function automatic logic [rcc_pkg::CSR_DATA_BITS-1:0] pick_value(int lo, int hi);
      int sel;
      sel = $urandom_range(0, 3);
      if (sel == 0) return rcc_pkg::CSR_DATA_BITS'(lo);
      if (sel == 1) return rcc_pkg::CSR_DATA_BITS'(hi);
      return rcc_pkg::CSR_DATA_BITS'($urandom_range(lo, hi));
   endfunction

   task automatic send_step(rcc_pkg::req_type it);
      int gap;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      axis_results_q.push_back(condition_step(it));
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (axis_results_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [rcc_pkg::CSR_INDEX_BITS-1:0] idx,
                                 logic [rcc_pkg::CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         rcc_pkg::CSR_INPUT_MIN:     cfg_input_min     = value[rcc_pkg::RAW_BITS-1:0];
         rcc_pkg::CSR_NORM_SCALE:    cfg_norm_scale    = value;
         rcc_pkg::CSR_DEADBAND:      cfg_deadband      = value[rcc_pkg::DB_BITS-1:0];
         rcc_pkg::CSR_SMOOTH_ALPHA:  cfg_alpha         = value;
         rcc_pkg::CSR_TIMEOUT_MS:    cfg_timeout       = value;
         rcc_pkg::CSR_ARM_THRESHOLD: cfg_arm_threshold = value[rcc_pkg::RAW_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_random_registers(bit wild);
      if (wild) begin
         write_register(rcc_pkg::CSR_INPUT_MIN, pick_value(0, 2047));
         write_register(rcc_pkg::CSR_NORM_SCALE, pick_value(0, 65535));
         write_register(rcc_pkg::CSR_DEADBAND, pick_value(0, 32767));
         write_register(rcc_pkg::CSR_SMOOTH_ALPHA, pick_value(0, 65535));
         write_register(rcc_pkg::CSR_TIMEOUT_MS, pick_value(0, 65535));
         write_register(rcc_pkg::CSR_ARM_THRESHOLD, pick_value(0, 2047));
      end else begin
         write_register(rcc_pkg::CSR_INPUT_MIN,
                        rcc_pkg::CSR_DATA_BITS'($urandom_range(150, 200)));
         write_register(rcc_pkg::CSR_NORM_SCALE,
                        rcc_pkg::CSR_DATA_BITS'($urandom_range(18000, 23000)));
         write_register(rcc_pkg::CSR_DEADBAND,
                        rcc_pkg::CSR_DATA_BITS'($urandom_range(0, 4000)));
         write_register(rcc_pkg::CSR_SMOOTH_ALPHA,
                        rcc_pkg::CSR_DATA_BITS'($urandom_range(500, 32768)));
         write_register(rcc_pkg::CSR_TIMEOUT_MS,
                        rcc_pkg::CSR_DATA_BITS'($urandom_range(10, 300)));
         write_register(rcc_pkg::CSR_ARM_THRESHOLD,
                        rcc_pkg::CSR_DATA_BITS'($urandom_range(900, 1100)));
      end
      if ($urandom_range(0, 2) == 0) write_register(CSR_SPARE_HI, pick_value(0, 65535));
   endtask

   task automatic test_reset_config();
      send_step(make_frame(992, 992, 992, 172, 0, 1'b0, 10));
      send_step(make_frame(0, 2047, 172, 2047, 2047, 1'b0, 255));
      send_step(make_frame(2047, 0, 1811, 0, 1000, 1'b0, 0));
      // deadband edges under the reset scaling
      send_step(make_frame(950, 1033, 951, 1024, 1001, 1'b0, 1));
      send_step(make_frame(951, 1032, 950, 1811, 1000, 1'b0, 1));
   endtask

   task automatic test_age_and_failsafe();
      send_step(make_frame(992, 992, 992, 500, 1500, 1'b0, 5));
      send_step(idle_step(100));
      send_step(idle_step(1));
      // failsafe frame keeps the age running
      send_step(make_frame(300, 1700, 800, 900, 1200, 1'b1, 0));
      send_step(make_frame(1700, 300, 1200, 1500, 400, 1'b0, 200));
      send_step(idle_step(0));
   endtask

   task automatic test_register_extremes();
      settle();
      write_register(rcc_pkg::CSR_INPUT_MIN, 16'd0);
      write_register(rcc_pkg::CSR_NORM_SCALE, 16'hFFFF);
      write_register(rcc_pkg::CSR_DEADBAND, 16'd0);
      write_register(rcc_pkg::CSR_SMOOTH_ALPHA, rcc_pkg::ALPHA_ONE);
      write_register(rcc_pkg::CSR_TIMEOUT_MS, 16'd0);
      write_register(rcc_pkg::CSR_ARM_THRESHOLD, 16'd0);
      send_step(make_frame(0, 2047, 1024, 2047, 0, 1'b0, 0));
      send_step(make_frame(2047, 0, 1, 1, 1, 1'b0, 1));
      send_step(idle_step(1));
      settle();
      write_register(rcc_pkg::CSR_INPUT_MIN, 16'd2047);
      write_register(rcc_pkg::CSR_NORM_SCALE, 16'd0);
      write_register(rcc_pkg::CSR_DEADBAND, 16'd32767);
      write_register(rcc_pkg::CSR_SMOOTH_ALPHA, 16'hFFFF);
      write_register(rcc_pkg::CSR_TIMEOUT_MS, 16'hFFFF);
      write_register(rcc_pkg::CSR_ARM_THRESHOLD, 16'd2047);
      send_step(make_frame(2047, 2047, 2047, 2047, 2047, 1'b0, 255));
      send_step(make_frame(0, 0, 0, 0, 0, 1'b1, 255));
      settle();
      // writes past the last register are dropped
      write_register(CSR_SPARE_LO, 16'hFFFF);
      write_register(CSR_SPARE_HI, 16'hFFFF);
      write_register(rcc_pkg::CSR_INPUT_MIN, rcc_pkg::RST_INPUT_MIN);
      write_register(rcc_pkg::CSR_NORM_SCALE, rcc_pkg::RST_NORM_SCALE);
      write_register(rcc_pkg::CSR_SMOOTH_ALPHA, 16'd0);
      send_step(make_frame(1811, 172, 1500, 1811, 2047, 1'b0, 3));
      send_step(idle_step(7));
   endtask

   task automatic test_age_saturation();
      settle();
      write_register(rcc_pkg::CSR_DEADBAND, rcc_pkg::RST_DEADBAND);
      write_register(rcc_pkg::CSR_SMOOTH_ALPHA, rcc_pkg::RST_SMOOTH_ALPHA);
      write_register(rcc_pkg::CSR_TIMEOUT_MS, 16'hFFFF);
      write_register(rcc_pkg::CSR_ARM_THRESHOLD, rcc_pkg::RST_ARM_THRESHOLD);
      send_step(make_frame(1200, 800, 992, 1400, 1800, 1'b0, 0));
      repeat (258) send_step(idle_step(255));
      settle();
      write_register(rcc_pkg::CSR_TIMEOUT_MS, 16'hFFFE);
      repeat (3) send_step(idle_step($urandom_range(0, 255)));
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < 5; p++) begin
         settle();
         load_random_registers(p[0]);
         idle_odds = $urandom_range(2, 8);
         repeat (75) send_step(random_step());
      end
   endtask

   task automatic test_quiet_tail();
      settle();
      load_random_registers(1'b0);
      idle_odds = 0;
      repeat (60) send_step(random_step());
      settle();
   endtask

   always begin : sink
      int hold;
      @(negedge clock);
      if (idle_odds != 0 && $urandom_range(1, idle_odds + 1) == 1) begin
         rsp_ready <= 1'b0;
         hold = $urandom_range(1, 6);
         repeat (hold - 1) @(negedge clock);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      rcc_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (axis_results_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: unexpected item %p", $realtime, rsp_data);
            end
         end else begin
            want = axis_results_q.pop_front();
            if (rsp_data.roll_out !== want.roll_out || rsp_data.pitch_out !== want.pitch_out ||
                rsp_data.yaw_out !== want.yaw_out ||
                rsp_data.throttle_out !== want.throttle_out ||
                rsp_data.is_armed !== want.is_armed ||
                rsp_data.signal_lost !== want.signal_lost) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: wrong item, expected roll %0d pitch %0d yaw %0d thr %0d %s",
                           $realtime, want.roll_out, want.pitch_out, want.yaw_out,
                           want.throttle_out,
                           $sformatf("arm %0b lost %0b", want.is_armed, want.signal_lost));
                  $display("   got roll %0d pitch %0d yaw %0d thr %0d arm %0b lost %0b",
                           rsp_data.roll_out, rsp_data.pitch_out, rsp_data.yaw_out,
                           rsp_data.throttle_out, rsp_data.is_armed, rsp_data.signal_lost);
               end
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("rc_channel_conditioner_top: mismatch");
      $finish;
   end

   initial begin
      reset_model();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      idle_odds = 4;
      test_reset_config();
      test_age_and_failsafe();
      test_register_extremes();
      test_age_saturation();
      test_random_phases();
      test_quiet_tail();
      if (mismatch_count == 0 && axis_results_q.size() == 0) begin
         $display("rc_channel_conditioner_top: match");
      end else begin
         $display("rc_channel_conditioner_top: mismatch");
      end
      $finish;
   end

endmodule
